### hw/rtl/ray_box_slab_test_defines.svh
// Assertion macros for the ray/box slab test checker.
// No dependencies; included by the checker file.
`ifndef RAY_BOX_SLAB_TEST_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_DEFINES_SVH

// Implication checked outside reset.
`define RBST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, also checked across reset.
`define RBST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/rbst_pkg.sv
// Shared types and constants for the ray/box slab test.
// No dependencies.
package rbst_pkg;

  localparam int NUM_AXES = 3;

  // Per-axis control flags produced by the slab setup stage
  typedef struct packed {
    logic neg_lo;   // box min below origin
    logic neg_hi;   // box max below origin
    logic dir_neg;  // direction negative
    logic parallel; // direction zero
    logic in_slab;  // origin within slab, inclusive
  } rbst_axis_flags_t;

endpackage

### hw/rtl/rbst_if.sv
// Channel interfaces for the ray/box slab test: request and response.
// No dependencies.
interface rbst_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_max_y;
  logic signed [63:0] box_bounds_z;
  logic signed [63:0] t_range;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  box_min_x, box_max_x, box_min_y, box_max_y, box_bounds_z, t_range,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                box_min_x, box_max_x, box_min_y, box_max_y, box_bounds_z, t_range,
                output ready);
endinterface

interface rbst_rsp_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

### hw/rtl/ray_box_slab_test.sv
// Ray versus axis-aligned box slab test, fixed point, one transaction per cycle.
// Stages: setup, COORD_WIDTH+2 divider stages (a saturation stage, then one quotient
// bit per stage), clamp and swap, one narrowing stage per axis.
// Throughput one transaction per cycle; a stalled response holds the whole pipeline.
// Synchronous active-high reset clears all valid bits; payload is not reset.
module ray_box_slab_test
  import rbst_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst,
  rbst_req_if.sink     req,
  rbst_rsp_if.source   rsp
);

  localparam int CW  = COORD_WIDTH;
  localparam int CWE = (CW < 32) ? CW : 32;
  localparam int NQ  = CW + 1;

  typedef struct packed {
    logic signed [CW-1:0]            ts;
    logic signed [CW-1:0]            te;
    rbst_axis_flags_t [NUM_AXES-1:0] fl;
  } side_t;

  logic en;

  // Whole pipeline moves unless the output holds an untaken result
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // Coordinate extraction
  logic signed [CWE-1:0] c_lo  [NUM_AXES];
  logic signed [CWE-1:0] c_hi  [NUM_AXES];
  logic signed [CWE-1:0] c_org [NUM_AXES];
  logic signed [CWE-1:0] c_dir [NUM_AXES];
  logic signed [CWE-1:0] c_ts, c_te;

  assign c_lo[0]  = req.box_min_x[CWE-1:0];
  assign c_hi[0]  = req.box_max_x[CWE-1:0];
  assign c_lo[1]  = req.box_min_y[CWE-1:0];
  assign c_hi[1]  = req.box_max_y[CWE-1:0];
  assign c_lo[2]  = req.box_bounds_z[CWE-1:0];
  assign c_hi[2]  = req.box_bounds_z[32+CWE-1:32];
  assign c_org[0] = req.origin_x[CWE-1:0];
  assign c_org[1] = req.origin_y[CWE-1:0];
  assign c_org[2] = req.origin_z[CWE-1:0];
  assign c_dir[0] = req.dir_x[CWE-1:0];
  assign c_dir[1] = req.dir_y[CWE-1:0];
  assign c_dir[2] = req.dir_z[CWE-1:0];
  assign c_ts     = req.t_range[CWE-1:0];
  assign c_te     = req.t_range[32+CWE-1:32];

  // Setup stage
  logic             vp;
  logic signed [CW-1:0] ts_p, te_p;
  logic [CWE:0]     mag_lo [NUM_AXES];
  logic [CWE:0]     mag_hi [NUM_AXES];
  logic [CWE-1:0]   dmag   [NUM_AXES];
  rbst_axis_flags_t fl_p   [NUM_AXES];
  logic [NQ-1:0]    q_lo   [NUM_AXES];
  logic [NQ-1:0]    q_hi   [NUM_AXES];
  logic             s_lo   [NUM_AXES];
  logic             s_hi   [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en) begin
      ts_p <= CW'(c_ts);
      te_p <= CW'(c_te);
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    rbst_prep #(.CWE(CWE)) u_prep (
      .clk(clk), .en(en), .lo(c_lo[a]), .hi(c_hi[a]), .org(c_org[a]), .dir(c_dir[a]),
      .mag_lo(mag_lo[a]), .mag_hi(mag_hi[a]), .dmag(dmag[a]), .flags(fl_p[a])
    );
    rbst_div #(.MW(CWE+1), .DMW(CWE), .FRAC_BITS(FRAC_BITS), .NQ(NQ)) u_div_lo (
      .clk(clk), .en(en), .mag(mag_lo[a]), .dmag(dmag[a]), .quo(q_lo[a]), .sat(s_lo[a])
    );
    rbst_div #(.MW(CWE+1), .DMW(CWE), .FRAC_BITS(FRAC_BITS), .NQ(NQ)) u_div_hi (
      .clk(clk), .en(en), .mag(mag_hi[a]), .dmag(dmag[a]), .quo(q_hi[a]), .sat(s_hi[a])
    );
  end

  // Sideband delay line matching the divider depth
  side_t side_s [0:NQ];
  logic  vd     [0:NQ];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
      for (int j = 0; j <= NQ; j++) vd[j] <= 1'b0;
    end else if (en) begin
      vp    <= req.valid;
      vd[0] <= vp;
      for (int j = 1; j <= NQ; j++) vd[j] <= vd[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_s[0].ts <= ts_p;
      side_s[0].te <= te_p;
      for (int a = 0; a < NUM_AXES; a++) side_s[0].fl[a] <= fl_p[a];
      for (int j = 1; j <= NQ; j++) side_s[j] <= side_s[j-1];
    end
  end

  // Clamp, sign and swap; index 0 holds this stage, 1..3 the narrowing stages
  logic signed [CW-1:0] ts_a    [0:NUM_AXES];
  logic signed [CW-1:0] te_a    [0:NUM_AXES];
  logic                 alive_a [0:NUM_AXES];
  logic                 v_a     [0:NUM_AXES];
  logic signed [CW-1:0] near_a  [0:NUM_AXES][NUM_AXES];
  logic signed [CW-1:0] far_a   [0:NUM_AXES][NUM_AXES];
  rbst_axis_flags_t     fl_a    [0:NUM_AXES][NUM_AXES];

  logic signed [CW-1:0] t_lo [NUM_AXES];
  logic signed [CW-1:0] t_hi [NUM_AXES];

  function automatic logic [CW-1:0] fix_quo(input logic [NQ-1:0] q, input logic s,
                                            input logic neg);
    logic [NQ-1:0] lim;
    logic [NQ-1:0] qc;
    lim = neg ? (NQ'(1) << (CW-1)) : ((NQ'(1) << (CW-1)) - NQ'(1));
    qc  = (s || (q > lim)) ? lim : q;
    return neg ? CW'(NQ'(-qc)) : qc[CW-1:0];
  endfunction

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      t_lo[a] = fix_quo(q_lo[a], s_lo[a],
                        side_s[NQ].fl[a].neg_lo ^ side_s[NQ].fl[a].dir_neg);
      t_hi[a] = fix_quo(q_hi[a], s_hi[a],
                        side_s[NQ].fl[a].neg_hi ^ side_s[NQ].fl[a].dir_neg);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ts_a[0]    <= side_s[NQ].ts;
      te_a[0]    <= side_s[NQ].te;
      alive_a[0] <= 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
        near_a[0][a] <= side_s[NQ].fl[a].dir_neg ? t_hi[a] : t_lo[a];
        far_a[0][a]  <= side_s[NQ].fl[a].dir_neg ? t_lo[a] : t_hi[a];
        fl_a[0][a]   <= side_s[NQ].fl[a];
      end
    end
  end

  // Narrow the interval one axis per stage
  for (genvar s = 1; s <= NUM_AXES; s++) begin : g_narrow
    localparam int AX = s - 1;
    logic signed [CW-1:0] ts_n, te_n;
    logic                 ok;

    always_comb begin
      if (fl_a[s-1][AX].parallel) begin
        ts_n = ts_a[s-1];
        te_n = te_a[s-1];
        ok   = fl_a[s-1][AX].in_slab;
      end else begin
        ts_n = (near_a[s-1][AX] > ts_a[s-1]) ? near_a[s-1][AX] : ts_a[s-1];
        te_n = (far_a[s-1][AX] < te_a[s-1]) ? far_a[s-1][AX] : te_a[s-1];
        ok   = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ts_a[s]    <= ts_n;
        te_a[s]    <= te_n;
        alive_a[s] <= alive_a[s-1] && ok && (te_n > ts_n);
        near_a[s]  <= near_a[s-1];
        far_a[s]   <= far_a[s-1];
        fl_a[s]    <= fl_a[s-1];
      end
    end
  end

  // Valid bits for the clamp and narrowing stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= NUM_AXES; s++) v_a[s] <= 1'b0;
    end else if (en) begin
      v_a[0] <= vd[NQ];
      for (int s = 1; s <= NUM_AXES; s++) v_a[s] <= v_a[s-1];
    end
  end

  assign rsp.valid = v_a[NUM_AXES];
  assign rsp.hit   = alive_a[NUM_AXES];

endmodule

### hw/rtl/rbst_prep.sv
// Slab setup for one axis: numerator magnitudes, divisor magnitude, flags.
// Depends on rbst_pkg.
module rbst_prep
  import rbst_pkg::*;
#(
  parameter int CWE = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [CWE-1:0] lo,
  input  logic signed [CWE-1:0] hi,
  input  logic signed [CWE-1:0] org,
  input  logic signed [CWE-1:0] dir,
  output logic        [CWE:0]   mag_lo,
  output logic        [CWE:0]   mag_hi,
  output logic        [CWE-1:0] dmag,
  output rbst_axis_flags_t      flags
);

  logic signed [CWE:0] diff_lo, diff_hi, dir_ext;

  // Differences at one extra bit so they never wrap
  assign diff_lo = (CWE+1)'(lo) - (CWE+1)'(org);
  assign diff_hi = (CWE+1)'(hi) - (CWE+1)'(org);
  assign dir_ext = (CWE+1)'(dir);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_lo         <= diff_lo[CWE] ? (CWE+1)'(-diff_lo) : diff_lo;
      mag_hi         <= diff_hi[CWE] ? (CWE+1)'(-diff_hi) : diff_hi;
      dmag           <= dir[CWE-1] ? CWE'(-dir_ext) : CWE'(dir_ext);
      flags.neg_lo   <= diff_lo[CWE];
      flags.neg_hi   <= diff_hi[CWE];
      flags.dir_neg  <= dir[CWE-1];
      flags.parallel <= (dir == '0);
      flags.in_slab  <= (org >= lo) && (org <= hi);
    end
  end

endmodule

### hw/rtl/rbst_div.sv
// Pipelined restoring divider: (mag << FRAC_BITS) / dmag, one quotient bit a stage.
// Flags saturation when the quotient needs more than NQ bits. No dependencies.
module rbst_div #(
  parameter int MW        = 33,
  parameter int DMW       = 32,
  parameter int FRAC_BITS = 16,
  parameter int NQ        = 33
) (
  input  logic           clk,
  input  logic           en,
  input  logic [MW-1:0]  mag,
  input  logic [DMW-1:0] dmag,
  output logic [NQ-1:0]  quo,
  output logic           sat
);

  localparam int NW   = MW + FRAC_BITS;
  localparam int RW   = DMW + 1;
  localparam int CMPW = NW + RW;

  logic [NW-1:0]  num_s [0:NQ];
  logic [DMW-1:0] den_s [0:NQ];
  logic [RW-1:0]  rem_s [0:NQ];
  logic [NQ-1:0]  quo_s [0:NQ];
  logic           sat_s [0:NQ];

  logic [NW-1:0]   num_in;
  logic [CMPW-1:0] top_part;

  assign num_in   = {mag, {FRAC_BITS{1'b0}}};
  assign top_part = CMPW'(num_in) >> NQ;

  // Stage 0: bits above the quotient range decide saturation
  always_ff @(posedge clk) begin
    if (en) begin
      num_s[0] <= num_in;
      den_s[0] <= dmag;
      rem_s[0] <= top_part[RW-1:0];
      quo_s[0] <= '0;
      sat_s[0] <= (top_part >= CMPW'(dmag));
    end
  end

  // One compare and subtract per stage, MSB first
  for (genvar k = 1; k <= NQ; k++) begin : g_step
    localparam int BI = NQ - k;
    logic          nbit;
    logic [RW:0]   shifted;
    logic          ge;

    if (BI < NW) begin : g_bit
      assign nbit = num_s[k-1][BI];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign shifted = {rem_s[k-1], nbit};
    assign ge      = (shifted >= (RW+1)'(den_s[k-1]));

    always_ff @(posedge clk) begin
      if (en) begin
        num_s[k] <= num_s[k-1];
        den_s[k] <= den_s[k-1];
        rem_s[k] <= ge ? RW'(shifted - (RW+1)'(den_s[k-1])) : shifted[RW-1:0];
        quo_s[k] <= {quo_s[k-1][NQ-2:0], ge};
        sat_s[k] <= sat_s[k-1];
      end
    end
  end

  assign quo = quo_s[NQ];
  assign sat = sat_s[NQ];

endmodule

### hw/rtl/rbst_checker.sv
// Port-level checker for ray_box_slab_test, attached by bind.
// Depends on ray_box_slab_test_defines.svh.
`include "ray_box_slab_test_defines.svh"

module rbst_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);

  logic stall;

  // Response waiting on the receiver
  assign stall = out_valid && !out_ready;

  // Nothing comes out in the cycle after reset
  `RBST_ASSERT_NEXT(a_no_out_after_rst, rst, !out_valid, "response valid right after reset")

  // A held response stalls a pending request
  `RBST_ASSERT_IMPL(a_stall_blocks_in, stall && in_valid, !in_ready, "request taken during stall")

  // An empty output stage always lets a transaction in
  `RBST_ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready, "not ready with empty output")

  // Stalled response keeps its result
  `RBST_ASSERT_NEXT(a_hold_hit, stall && !rst, out_valid && $stable(out_hit), "held response changed")

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_hit   (rsp.hit)
);
